/* sv/tbc_pkg.sv */
// shared types and constants of the translated block cache
// used by tbc_hash, tbc_engine and translated_block_cache_top; no dependencies
package tbc_pkg;

  localparam int HashBits = 10;
  localparam int NumSlots = 1 << HashBits;

  localparam logic [63:0] FibMul = 64'h9e3779b97f4a7c15;

  localparam int RegionW = 25;
  localparam int OffsetW = 24;
  localparam int SizeW   = 25;
  localparam int SlotW   = 10;
  localparam int BlkW    = 11;
  localparam int FreedW  = 32;

  localparam logic [RegionW-1:0] RegionReset = 25'd262144;
  localparam logic [RegionW-1:0] RegionMax   = 25'd16777216;

  typedef enum logic [1:0] {
    KIND_INSERT     = 2'd0,
    KIND_LOOKUP     = 2'd1,
    KIND_FREE_RANGE = 2'd2,
    KIND_FREE_ALL   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [63:0]       paddr;
    logic [63:0]       range_end;
    logic [SizeW-1:0]  block_bytes;
  } tbc_in_t;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot;
    logic               evicted;
    logic [OffsetW-1:0] code_offset;
    logic [SizeW-1:0]   code_bytes;
    logic [BlkW-1:0]    blocks_in_use;
    logic [SizeW-1:0]   bytes_used;
    logic [FreedW-1:0]  bytes_freed;
  } tbc_out_t;

  // one table entry
  typedef struct packed {
    logic               valid;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   size;
  } slot_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] word;
  } hash_req_t;

  typedef struct packed {
    logic                done;
    logic [HashBits-1:0] slot;
  } hash_rsp_t;

endpackage

/* sv/tbc_hash.sv */
// iterative fibonacci hash: top HashBits bits of the low 64 bits of word * FibMul
// one shared 32x32 multiplier over three steps; depends on tbc_pkg
module tbc_hash import tbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hash_req_t req_i,
  output hash_rsp_t rsp_o
);

  localparam logic [31:0] FibLo = FibMul[31:0];
  localparam logic [31:0] FibHi = FibMul[63:32];

  typedef enum logic [3:0] {
    HS_IDLE = 4'b0001,
    HS_LO   = 4'b0010,
    HS_XA   = 4'b0100,
    HS_XB   = 4'b1000
  } hstate_e;

  hstate_e             state_q, state_d;
  logic [63:0]         word_q, word_d;
  logic [63:0]         acc_q, acc_d;
  logic                done_q, done_d;
  logic [HashBits-1:0] slot_q, slot_d;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod;

  // cross terms only reach the upper half of the 64-bit product
  assign mul_a = (state_q == HS_XB) ? word_q[63:32] : word_q[31:0];
  assign mul_b = (state_q == HS_XA) ? FibHi : FibLo;
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    slot_d  = slot_q;
    unique case (state_q)
      HS_IDLE: begin
        if (req_i.start) begin
          word_d  = req_i.word;
          state_d = HS_LO;
        end
      end
      HS_LO: begin
        acc_d   = prod;
        state_d = HS_XA;
      end
      HS_XA: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d      = HS_XB;
      end
      HS_XB: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        slot_d       = acc_d[63 -: HashBits];
        done_d       = 1'b1;
        state_d      = HS_IDLE;
      end
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    acc_q  <= acc_d;
    slot_q <= slot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.slot = slot_q;

endmodule

/* sv/tbc_engine.sv */
// operation sequencer around the slot memory: read-modify-write, range walk,
// clearing sweep and the allocation counters; depends on tbc_pkg
module tbc_engine import tbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RegionW-1:0] region_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbc_in_t            in_data_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output tbc_out_t           res_data_o,
  output hash_req_t          hash_req_o,
  input  hash_rsp_t          hash_rsp_i
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HASH   = 6'b000100,
    ST_WHASH  = 6'b001000,
    ST_MODIFY = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [63:0]         word_q, word_d;
  logic [64:0]         diff_q, diff_d;
  logic [62:0]         rem_q, rem_d;
  logic [SizeW-1:0]    size_q, size_d;
  logic [HashBits-1:0] slot_q, slot_d;
  logic [HashBits-1:0] cur_q, cur_d;
  logic [HashBits-1:0] clr_q, clr_d;
  logic [SizeW-1:0]    used_q, used_d;
  logic [FreedW-1:0]   freed_q, freed_d;
  logic [HashBits:0]   count_q, count_d;
  status_e             status_q, status_d;
  logic                evicted_q, evicted_d;
  logic [OffsetW-1:0]  off_q, off_d;
  logic [SizeW-1:0]    bytes_q, bytes_d;

  slot_entry_t         slot_mem_q [NumSlots];
  slot_entry_t         rd_data_q;
  logic                mem_re, mem_we;
  logic [HashBits-1:0] mem_raddr, mem_waddr;
  slot_entry_t         mem_wdata;

  logic [FreedW:0]     freed_sum;
  logic [FreedW-1:0]   freed_sat;
  logic [SizeW:0]      ins_sum;
  logic                ins_full;
  logic [62:0]         n_words;
  logic                range_empty;
  logic [HashBits:0]   count_next;

  assign freed_sum   = {1'b0, freed_q} + (FreedW + 1)'(rd_data_q.size);
  assign freed_sat   = freed_sum[FreedW] ? '1 : freed_sum[FreedW-1:0];
  assign ins_sum     = {1'b0, used_q} + {1'b0, size_q};
  assign ins_full    = ins_sum >= {1'b0, region_i};
  // word count of the range, a partial last word counts
  assign n_words     = {1'b0, diff_q[63:2]} + 63'(|diff_q[1:0]);
  assign range_empty = diff_q[64] || (diff_q[63:0] == 64'd0);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    word_d     = word_q;
    diff_d     = diff_q;
    rem_d      = rem_q;
    size_d     = size_q;
    slot_d     = slot_q;
    cur_d      = cur_q;
    clr_d      = clr_q;
    used_d     = used_q;
    freed_d    = freed_q;
    count_d    = count_q;
    status_d   = status_q;
    evicted_d  = evicted_q;
    off_d      = off_q;
    bytes_d    = bytes_q;
    count_next = count_q;
    hash_req_o = '{start: 1'b0, word: word_q};
    mem_re     = 1'b0;
    mem_raddr  = hash_rsp_i.slot;
    mem_we     = 1'b0;
    mem_waddr  = cur_q;
    mem_wdata  = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = (kind_q == KIND_FREE_ALL) ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d     = in_data_i.kind;
          word_d     = {2'b00, in_data_i.paddr[63:2]};
          diff_d     = {1'b0, in_data_i.range_end} - {1'b0, in_data_i.paddr};
          size_d     = in_data_i.block_bytes;
          status_d   = STATUS_OK;
          evicted_d  = 1'b0;
          off_d      = '0;
          bytes_d    = '0;
          hash_req_o = '{start: 1'b1, word: {2'b00, in_data_i.paddr[63:2]}};
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_rsp_i.done) begin
          slot_d = hash_rsp_i.slot;
          cur_d  = hash_rsp_i.slot;
          case (kind_q) inside
            KIND_INSERT, KIND_LOOKUP: begin
              mem_re  = 1'b1;
              state_d = ST_MODIFY;
            end
            KIND_FREE_RANGE: begin
              // the first word of the range is the address just hashed
              if (range_empty || count_q == '0) begin
                state_d = ST_DONE;
              end else begin
                rem_d   = n_words;
                mem_re  = 1'b1;
                state_d = ST_MODIFY;
              end
            end
            default: begin
              used_d  = '0;
              freed_d = '0;
              count_d = '0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
          endcase
        end
      end
      ST_WHASH: begin
        if (hash_rsp_i.done) begin
          cur_d   = hash_rsp_i.slot;
          mem_re  = 1'b1;
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        case (kind_q)
          KIND_INSERT: begin
            if (ins_full) begin
              status_d = STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{valid: 1'b1, offset: used_q[OffsetW-1:0], size: size_q};
              if (rd_data_q.valid) begin
                evicted_d = 1'b1;
                freed_d   = freed_sat;
              end else begin
                count_d = count_q + 1'b1;
              end
              off_d   = used_q[OffsetW-1:0];
              bytes_d = size_q;
              used_d  = ins_sum[SizeW-1:0];
            end
            state_d = ST_DONE;
          end
          KIND_LOOKUP: begin
            if (rd_data_q.valid) begin
              off_d   = rd_data_q.offset;
              bytes_d = rd_data_q.size;
            end else begin
              status_d = STATUS_MISS;
            end
            state_d = ST_DONE;
          end
          KIND_FREE_RANGE: begin
            if (rd_data_q.valid) begin
              mem_we     = 1'b1;
              freed_d    = freed_sat;
              count_next = count_q - 1'b1;
            end
            count_d = count_next;
            rem_d   = rem_q - 1'b1;
            // nothing left to free once the table is empty
            if (rem_q == 63'd1 || count_next == '0) begin
              state_d = ST_DONE;
            end else begin
              word_d     = word_q + 64'd1;
              hash_req_o = '{start: 1'b1, word: word_q + 64'd1};
              state_d    = ST_WHASH;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    res_data_o.status        = status_q;
    res_data_o.slot          = SlotW'(slot_q);
    res_data_o.evicted       = evicted_q;
    res_data_o.code_offset   = off_q;
    res_data_o.code_bytes    = bytes_q;
    res_data_o.blocks_in_use = BlkW'(count_q);
    res_data_o.bytes_used    = used_q;
    res_data_o.bytes_freed   = freed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      kind_q  <= KIND_INSERT;
      clr_q   <= '0;
      used_q  <= '0;
      freed_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      freed_q <= freed_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    size_q    <= size_d;
    slot_q    <= slot_d;
    cur_q     <= cur_d;
    status_q  <= status_d;
    evicted_q <= evicted_d;
    off_q     <= off_d;
    bytes_q   <= bytes_d;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_raddr];
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("slot memory read and write in the same cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (HashBits + 1)'(NumSlots))
    else $error("block count above table size");

  a_hash_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_rsp_i.done |-> (state_q == ST_HASH || state_q == ST_WHASH))
    else $error("hash result while not waiting for one");

  a_free_all_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && kind_q == KIND_FREE_ALL)
      |-> (count_q == '0 && used_q == '0 && freed_q == '0))
    else $error("counters not cleared after free all");

  a_walk_stops_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && kind_q == KIND_FREE_RANGE && count_next == '0)
      |=> state_q == ST_DONE)
    else $error("range walk continued on an empty table");

endmodule

/* sv/translated_block_cache_top.sv */
// translated block cache top level: region size register, result register,
// engine and hash unit; depends on tbc_pkg, tbc_hash and tbc_engine
//
//  port group    dir  handshake              payload
//  in_*          in   in_valid_i/in_stall_o  tbc_in_t   kind, paddr, range_end, block_bytes
//  out_*         out  out_valid_o/out_stall_i tbc_out_t status ... bytes_freed
//  cfg_*         in   cfg_we_i               region_bytes, 25 bits, clamped to 2^24
//
// insert and lookup: 3 hash steps on the shared multiplier, one memory read,
// a modify step (a write for insert only) and one result transfer.
// free range hashes, reads and updates each word, and stops once the table is empty.
// free all and reset both run a clearing sweep over all 2^HashBits slots (1024)
// through the slot memory; no item is taken meanwhile, config writes are.
// a finished result waits in the output register so a new item can enter under stall.
module translated_block_cache_top import tbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegionW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbc_out_t           out_data_o
);

  logic [RegionW-1:0] region_q, region_d;
  logic               out_valid_q, out_valid_d;
  tbc_out_t           out_data_q, out_data_d;
  logic               res_valid, res_ready;
  tbc_out_t           res_data;
  hash_req_t          hash_req;
  hash_rsp_t          hash_rsp;

  assign region_d = !cfg_we_i ? region_q :
                    (cfg_wdata_i > RegionMax) ? RegionMax : cfg_wdata_i;

  // output register frees up when empty or when its transfer completes
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = res_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= RegionReset;
      out_valid_q <= 1'b0;
    end else begin
      region_q    <= region_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tbc_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  tbc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .region_i    (region_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .hash_req_o  (hash_req),
    .hash_rsp_i  (hash_rsp)
  );

endmodule
